@@ hdl/kra_pkg.sv @@
// Shared types and constants for the keyed run sum/count aggregator.
// No dependencies.
package kra_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 3;

  typedef enum logic [1:0] {
    AGG_SUM    = 2'd0,
    AGG_ITEMS  = 2'd1,
    AGG_COUNTS = 2'd2,
    AGG_AVG    = 2'd3
  } agg_mode_e;

  typedef enum logic {
    REG_AGG_MODE     = 1'b0,
    REG_GROUP_BY_KEY = 1'b1
  } reg_idx_e;

  localparam agg_mode_e AggModeRst    = AGG_COUNTS;
  localparam logic      GroupByKeyRst = 1'b1;

  typedef struct packed {
    agg_mode_e agg_mode;
    logic      group_by_key;
  } cfg_t;

endpackage

@@ hdl/kra_if.sv @@
// Record and aggregate channels (valid/ready) of the aggregator.
// Depends on kra_pkg.
interface kra_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [kra_pkg::DataW-1:0] in_key;
  logic signed [kra_pkg::DataW-1:0] in_value;
  logic signed [kra_pkg::DataW-1:0] in_count;
  logic                           in_last;

  modport source (output valid, in_key, in_value, in_count, in_last, input ready);
  modport sink   (input valid, in_key, in_value, in_count, in_last, output ready);
endinterface

interface kra_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [kra_pkg::DataW-1:0] out_key;
  logic signed [kra_pkg::DataW-1:0] out_value;
  logic signed [kra_pkg::DataW-1:0] out_count;
  logic                           div_by_zero;
  logic                           out_last;

  modport source (output valid, out_key, out_value, out_count, div_by_zero, out_last,
                  input ready);
  modport sink   (input valid, out_key, out_value, out_count, div_by_zero, out_last,
                  output ready);
endinterface

@@ hdl/kra_cfg.sv @@
// APB register file: aggregation mode and grouping select.
// Depends on kra_pkg.
module kra_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kra_pkg::AddrW-1:0]  paddr,
  input  logic [kra_pkg::DataW-1:0]  pwdata,
  output logic [kra_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output kra_pkg::cfg_t              cfg_o
);

  kra_pkg::cfg_t    cfg_q;
  kra_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = kra_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.agg_mode     <= kra_pkg::AggModeRst;
      cfg_q.group_by_key <= kra_pkg::GroupByKeyRst;
    end else if (wr_en) begin
      unique case (idx)
        kra_pkg::REG_AGG_MODE:     cfg_q.agg_mode     <= kra_pkg::agg_mode_e'(pwdata[1:0]);
        kra_pkg::REG_GROUP_BY_KEY: cfg_q.group_by_key <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      kra_pkg::REG_AGG_MODE:     prdata[1:0] = cfg_q.agg_mode;
      kra_pkg::REG_GROUP_BY_KEY: prdata[0]   = cfg_q.group_by_key;
      default: ;
    endcase
  end

endmodule

@@ hdl/kra_div.sv @@
// Iterative signed 32/32 divider, one quotient bit per cycle, truncating.
// Depends on kra_pkg.
module kra_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [kra_pkg::DataW-1:0] dividend_i,
  input  logic signed [kra_pkg::DataW-1:0] divisor_i,
  output logic                            done_o,
  output logic signed [kra_pkg::DataW-1:0] quotient_o
);

  localparam int unsigned W  = kra_pkg::DataW;
  localparam int unsigned SW = $clog2(W);

  logic          busy_q, done_q, neg_q;
  logic [SW-1:0] step_q;
  logic [W-1:0]  rem_q, quo_q, dvs_q;
  logic [W-1:0]  dvd_mag, dvs_mag, quo_neg;
  logic [W+1:0]  trial;

  assign dvd_mag = dividend_i[W-1] ? W'(-dividend_i) : W'(dividend_i);
  assign dvs_mag = divisor_i[W-1]  ? W'(-divisor_i)  : W'(divisor_i);
  assign trial   = {1'b0, rem_q, quo_q[W-1]} - {2'b00, dvs_q};
  assign quo_neg = W'(-quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        neg_q  <= dividend_i[W-1] ^ divisor_i[W-1];
        step_q <= '0;
        rem_q  <= '0;
        quo_q  <= dvd_mag;
        dvs_q  <= dvs_mag;
      end else if (busy_q) begin
        if (!trial[W+1]) begin
          rem_q <= trial[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[W-2:0], quo_q[W-1]};
          quo_q <= {quo_q[W-2:0], 1'b0};
        end
        step_q <= step_q + 1'b1;
        if (step_q == SW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;

  always_comb begin
    if (neg_q) begin
      quotient_o = quo_neg;
    end else if (quo_q[W-1]) begin
      quotient_o = {1'b0, {(W-1){1'b1}}};
    end else begin
      quotient_o = quo_q;
    end
  end

endmodule

@@ hdl/keyed_run_sum_count_aggregator_core.sv @@
// Keyed run aggregator top: record intake, group state, emit sequencer.
// Depends on kra_pkg, kra_if, kra_cfg, kra_div.
// A record that closes no group leaves the sequencer idle; one that closes a group passes
// through S_CALC and S_OUT, and in average mode with a nonzero count through S_DIV, where
// the bit-serial divider runs. A second aggregate from the same record goes through these
// states again; output stalls hold S_OUT. Reset clears all state; registers reset to mode 2 by key.
module keyed_run_sum_count_aggregator_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  kra_in_if.sink                    in_i,
  kra_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kra_pkg::AddrW-1:0] paddr,
  input  logic [kra_pkg::DataW-1:0] pwdata,
  output logic [kra_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  localparam int unsigned W = kra_pkg::DataW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [W-1:0] key;
    logic [W-1:0] sum;
    logic [W-1:0] cnt;
    logic         last;
  } slot_t;

  kra_pkg::cfg_t cfg;

  state_e       state_q, state_d;
  logic [W-1:0] key_q, key_d, sum_q, sum_d, cnt_q, cnt_d;
  logic         open_q, open_d;
  slot_t        slot_a_q, slot_a_d, slot_b_q, slot_b_d;
  logic         pend_b_q, pend_b_d;
  logic [W-1:0] res_val_q, res_val_d;
  logic         res_dz_q, res_dz_d;
  logic         ov_q, ov_d;
  logic [W-1:0] ok_q, ok_d, oval_q, oval_d, ocnt_q, ocnt_d;
  logic         odz_q, odz_d, olast_q, olast_d;

  logic         in_acc, key_chg, fresh, div_start, div_done, load_out;
  logic [W-1:0] base_key, base_sum, base_cnt, new_sum, new_cnt, div_q;
  slot_t        new_slot;

  kra_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kra_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (slot_a_q.sum),
    .divisor_i  (slot_a_q.cnt),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  assign key_chg  = open_q && cfg.group_by_key && (in_i.in_key != key_q);
  assign fresh    = !open_q || key_chg;
  assign base_key = fresh ? in_i.in_key : key_q;
  assign base_sum = fresh ? '0 : sum_q;
  assign base_cnt = fresh ? '0 : cnt_q;
  assign new_sum  = base_sum + in_i.in_value;
  assign new_cnt  = base_cnt + ((cfg.agg_mode == kra_pkg::AGG_ITEMS) ? W'(1) : in_i.in_count);
  assign new_slot = '{key: base_key, sum: new_sum, cnt: new_cnt, last: 1'b1};

  assign div_start = (state_q == S_CALC) && (cfg.agg_mode == kra_pkg::AGG_AVG) &&
                     (slot_a_q.cnt != '0);
  assign load_out  = (state_q == S_OUT) && (!ov_q || out_o.ready);

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    open_d    = open_q;
    slot_a_d  = slot_a_q;
    slot_b_d  = slot_b_q;
    pend_b_d  = pend_b_q;
    res_val_d = res_val_q;
    res_dz_d  = res_dz_q;
    ov_d      = ov_q && !out_o.ready;
    ok_d      = ok_q;
    oval_d    = oval_q;
    ocnt_d    = ocnt_q;
    odz_d     = odz_q;
    olast_d   = olast_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.in_last) begin
            key_d  = '0;
            sum_d  = '0;
            cnt_d  = '0;
            open_d = 1'b0;
          end else begin
            key_d  = base_key;
            sum_d  = new_sum;
            cnt_d  = new_cnt;
            open_d = 1'b1;
          end
          slot_b_d = new_slot;
          pend_b_d = key_chg && in_i.in_last;
          if (key_chg) begin
            slot_a_d = slot_t'{key: key_q, sum: sum_q, cnt: cnt_q, last: 1'b0};
          end else begin
            slot_a_d = new_slot;
          end
          if (key_chg || in_i.in_last) begin
            state_d = S_CALC;
          end
        end
      end
      S_CALC: begin
        res_dz_d  = 1'b0;
        res_val_d = slot_a_q.sum;
        if (cfg.agg_mode == kra_pkg::AGG_AVG) begin
          if (slot_a_q.cnt == '0) begin
            res_val_d = '0;
            res_dz_d  = 1'b1;
            state_d   = S_OUT;
          end else begin
            state_d = S_DIV;
          end
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_val_d = div_q;
          state_d   = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) begin
          ov_d    = 1'b1;
          ok_d    = slot_a_q.key;
          oval_d  = res_val_q;
          ocnt_d  = (cfg.agg_mode == kra_pkg::AGG_SUM) ? '0 : slot_a_q.cnt;
          odz_d   = res_dz_q;
          olast_d = slot_a_q.last;
          if (pend_b_q) begin
            slot_a_d = slot_b_q;
            pend_b_d = 1'b0;
            state_d  = S_CALC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      key_q     <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
      open_q    <= 1'b0;
      slot_a_q  <= '0;
      slot_b_q  <= '0;
      pend_b_q  <= 1'b0;
      res_val_q <= '0;
      res_dz_q  <= 1'b0;
      ov_q      <= 1'b0;
      ok_q      <= '0;
      oval_q    <= '0;
      ocnt_q    <= '0;
      odz_q     <= 1'b0;
      olast_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      key_q     <= key_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      open_q    <= open_d;
      slot_a_q  <= slot_a_d;
      slot_b_q  <= slot_b_d;
      pend_b_q  <= pend_b_d;
      res_val_q <= res_val_d;
      res_dz_q  <= res_dz_d;
      ov_q      <= ov_d;
      ok_q      <= ok_d;
      oval_q    <= oval_d;
      ocnt_q    <= ocnt_d;
      odz_q     <= odz_d;
      olast_q   <= olast_d;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.out_key     = ok_q;
  assign out_o.out_value   = oval_q;
  assign out_o.out_count   = ocnt_q;
  assign out_o.div_by_zero = odz_q;
  assign out_o.out_last    = olast_q;

  a_div_only_avg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (cfg.agg_mode == kra_pkg::AGG_AVG) && (slot_a_q.cnt != '0))
    else $error("divider started outside average mode or with zero count");

  a_busy_after_close : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (key_chg || in_i.in_last) |=> !in_i.ready)
    else $error("record intake not stalled while a group is emitted");

  a_pend_not_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_b_q |-> (state_q != S_IDLE))
    else $error("second aggregate pending while sequencer idle");

  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the wait state");

endmodule

@@ bench/kra_checker.sv @@
// Checker for the keyed run aggregator: tracks register writes and accepted
// records, predicts the aggregate words and compares them with the output.
// Depends on kra_pkg and kra_if.
module kra_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  kra_in_if                         rec_w,
  kra_out_if                        agg_w,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [kra_pkg::AddrW-1:0] paddr,
  input  logic [kra_pkg::DataW-1:0] pwdata,
  output int unsigned               errors_o,
  output int unsigned               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DataW = kra_pkg::DataW;
  localparam int unsigned AddrW = kra_pkg::AddrW;

  typedef struct packed {
    logic [DataW-1:0] key;
    logic [DataW-1:0] value;
    logic [DataW-1:0] count;
    logic             dz;
    logic             last;
  } agg_word_t;

  kra_pkg::agg_mode_e mode_q;
  logic               by_key_q;
  logic [DataW-1:0]   grp_key;
  logic [DataW-1:0]   grp_sum;
  logic [DataW-1:0]   grp_cnt;
  logic               grp_open;
  agg_word_t          pending_aggs[$];
  int unsigned        n_errors = 0;

  assign errors_o = n_errors;

  task automatic report(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    n_errors++;
  endtask

  function automatic agg_word_t close_group(input logic last);
    agg_word_t w;
    longint    quot;
    w = '{key: grp_key, value: grp_sum, count: grp_cnt, dz: 1'b0, last: last};
    case (mode_q)
      kra_pkg::AGG_SUM: w.count = '0;
      kra_pkg::AGG_AVG: begin
        if (grp_cnt == '0) begin
          w.value = '0;
          w.dz    = 1'b1;
        end else begin
          quot = longint'($signed(grp_sum)) / longint'($signed(grp_cnt));
          if (quot > 64'sd2147483647) quot = 64'sd2147483647;
          w.value = quot[DataW-1:0];
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic start_group(input logic [DataW-1:0] k);
    grp_key  = k;
    grp_sum  = '0;
    grp_cnt  = '0;
    grp_open = 1'b1;
  endtask

  task automatic take_record(input logic [DataW-1:0] k, v, c, input logic l);
    if (!grp_open) begin
      start_group(k);
    end else if (by_key_q && k != grp_key) begin
      pending_aggs.push_back(close_group(1'b0));
      start_group(k);
    end
    grp_sum = grp_sum + v;
    grp_cnt = grp_cnt + ((mode_q == kra_pkg::AGG_ITEMS) ? DataW'(1) : c);
    if (l) begin
      pending_aggs.push_back(close_group(1'b1));
      grp_key  = '0;
      grp_sum  = '0;
      grp_cnt  = '0;
      grp_open = 1'b0;
    end
  endtask

  task automatic cmp_field(input string name, input logic [DataW-1:0] got, exp,
                           input logic [DataW-1:0] key);
    if (got !== exp)
      report($sformatf("%s of group %h: got %h, expected %h", name, key, got, exp));
  endtask

  task automatic check_word(input agg_word_t got);
    agg_word_t exp;
    if (pending_aggs.size() == 0) begin
      report($sformatf("word with key %h arrived, none expected", got.key));
      return;
    end
    exp = pending_aggs.pop_front();
    cmp_field("key", got.key, exp.key, exp.key);
    cmp_field("value", got.value, exp.value, exp.key);
    cmp_field("count", got.count, exp.count, exp.key);
    cmp_field("div_by_zero", DataW'(got.dz), DataW'(exp.dz), exp.key);
    cmp_field("last", DataW'(got.last), DataW'(exp.last), exp.key);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   = kra_pkg::AggModeRst;
      by_key_q = kra_pkg::GroupByKeyRst;
      grp_key  = '0;
      grp_sum  = '0;
      grp_cnt  = '0;
      grp_open = 1'b0;
      pending_aggs.delete();
    end else begin
      // output first: a word leaving now never stems from a record taken now
      if (agg_w.valid && agg_w.ready)
        check_word({agg_w.out_key, agg_w.out_value, agg_w.out_count,
                    agg_w.div_by_zero, agg_w.out_last});
      if (psel && penable && pwrite && pready) begin
        case (kra_pkg::reg_idx_e'(paddr[AddrW-1]))
          kra_pkg::REG_AGG_MODE:     mode_q = kra_pkg::agg_mode_e'(pwdata[1:0]);
          kra_pkg::REG_GROUP_BY_KEY: by_key_q = pwdata[0];
          default: ;
        endcase
      end
      if (rec_w.valid && rec_w.ready)
        take_record(rec_w.in_key, rec_w.in_value, rec_w.in_count, rec_w.in_last);
    end
    pending_o = pending_aggs.size();
  end

endmodule

@@ bench/keyed_run_sum_count_aggregator_core_tb.sv @@
// Testbench top for the keyed run aggregator: clock, reset, register writes,
// record stimulus and output backpressure; verdict from kra_checker.
// Depends on kra_pkg, kra_if, kra_checker and the aggregator core.
module keyed_run_sum_count_aggregator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DataW = kra_pkg::DataW;
  localparam int unsigned AddrW = kra_pkg::AddrW;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned ItemsPerPhase = 200;
  localparam int unsigned HoldCycles = 400;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  int unsigned      n_errors;
  int unsigned      n_pending;
  int unsigned      item_no = 0;

  kra_in_if  rec_w();
  kra_out_if agg_w();

  keyed_run_sum_count_aggregator_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (rec_w),
    .out_o   (agg_w),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  kra_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rec_w     (rec_w),
    .agg_w     (agg_w),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors_o  (n_errors),
    .pending_o (n_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_record(input logic [DataW-1:0] k, v, c, input logic l);
    int unsigned gap;
    gap = ((item_no / 50) % 4 == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      rec_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rec_w.valid    <= 1'b1;
    rec_w.in_key   <= k;
    rec_w.in_value <= v;
    rec_w.in_count <= c;
    rec_w.in_last  <= l;
    @(posedge clk_i);
    while (!rec_w.ready) @(posedge clk_i);
    item_no++;
  endtask

  task automatic wait_idle();
    rec_w.valid <= 1'b0;
    @(posedge clk_i);
    while (n_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input kra_pkg::reg_idx_e idx, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic set_config(input kra_pkg::agg_mode_e m, input logic by_key);
    wait_idle();
    write_reg(kra_pkg::REG_AGG_MODE, DataW'(m));
    write_reg(kra_pkg::REG_GROUP_BY_KEY, DataW'(by_key));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [DataW-1:0] pick_word(input int unsigned span);
    logic [DataW-1:0] extremes[4];
    int unsigned r;
    extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    r = $urandom_range(0, 9);
    if (r <= 5) return DataW'($urandom_range(0, 2 * span)) - DataW'(span);
    if (r <= 8) return $urandom;
    return extremes[$urandom_range(0, 3)];
  endfunction

  function automatic logic [DataW-1:0] next_key(input logic [DataW-1:0] k);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r <= 6) return k + DataW'($urandom_range(1, 50));
    if (r == 7) return $urandom;
    if (r == 8) return pick_word(0) ^ ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h0);
    return k + 1;
  endfunction

  // sorted runs inside batches, with some unsorted keys and stray batch ends
  task automatic run_batches(input int unsigned n_items);
    logic [DataW-1:0] key;
    logic [DataW-1:0] k;
    logic             noise;
    logic             last;
    int unsigned      run_left;
    int unsigned      batch_left;
    key        = $urandom;
    run_left   = 0;
    batch_left = 0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        key      = next_key(key);
        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 5);
      end
      if (batch_left == 0) batch_left = $urandom_range(1, 25);
      noise = ($urandom_range(0, 9) == 0);
      k     = noise ? DataW'($urandom) : key;
      last  = (batch_left == 1) || (noise && $urandom_range(0, 3) == 0);
      send_record(k, pick_word(100), pick_word(3), last);
      run_left--;
      batch_left = last ? 0 : batch_left - 1;
    end
  endtask

  // output side: random stalls, calm stretches and two long hold-offs
  initial begin
    int unsigned stall;
    int unsigned words;
    words = 0;
    agg_w.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (words == 60 || words == 300) stall = HoldCycles;
      else if ((words / 40) % 4 == 1) stall = 0;
      else stall = $urandom_range(0, 10);
      if (stall > 0) begin
        agg_w.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      agg_w.ready <= 1'b1;
      @(posedge clk_i);
      while (!agg_w.valid) @(posedge clk_i);
      words++;
    end
  end

  initial begin
    kra_pkg::agg_mode_e modes[10];
    logic               groupings[10];
    rec_w.valid    <= 1'b0;
    rec_w.in_key   <= '0;
    rec_w.in_value <= '0;
    rec_w.in_count <= '0;
    rec_w.in_last  <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    rst_ni         <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: sums by key with input counts
    send_record(32'h0, 32'h7fff_ffff, 32'h1, 1'b0);
    send_record(32'h0, 32'h1, 32'h0, 1'b0);                    // sum wraps
    send_record(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_record(32'h8000_0000, 32'hffff_ffff, 32'h1, 1'b0);    // count wraps
    send_record(32'h7fff_ffff, 32'h5, 32'h3, 1'b1);            // key change and end
    send_record(32'h7fff_ffff, 32'h9, 32'h2, 1'b1);            // lone record

    set_config(kra_pkg::AGG_AVG, 1'b1);
    send_record(32'h1, 32'h5, 32'h0, 1'b1);                    // zero count
    send_record(32'h2, 32'h8000_0000, 32'hffff_ffff, 1'b1);    // saturating quotient
    send_record(32'h3, 32'hffff_fff9, 32'h2, 1'b0);
    send_record(32'h3, 32'h0, 32'h0, 1'b1);                    // truncates toward zero
    send_record(32'h4, 32'h100, 32'h3, 1'b0);
    send_record(32'h5, 32'h7, 32'h7, 1'b1);

    set_config(kra_pkg::AGG_ITEMS, 1'b1);
    send_record(32'h6, 32'h1, 32'hffff_ffff, 1'b0);
    send_record(32'h6, 32'h2, 32'h0, 1'b0);
    send_record(32'h6, 32'h3, 32'h5, 1'b1);
    send_record(32'h8, 32'h4, 32'h9, 1'b0);                    // left open

    set_config(kra_pkg::AGG_SUM, 1'b0);                        // switched mid-group
    send_record(32'h9, 32'ha, 32'h4, 1'b0);
    send_record(32'h8000_0000, 32'h14, 32'h1, 1'b1);
    send_record(32'hffff_ffff, 32'h1, 32'h1, 1'b0);
    send_record(32'h0, 32'h2, 32'h2, 1'b0);
    send_record(32'h7fff_ffff, 32'h3, 32'h3, 1'b1);

    modes     = '{kra_pkg::AGG_COUNTS, kra_pkg::AGG_AVG, kra_pkg::AGG_ITEMS,
                  kra_pkg::AGG_SUM, kra_pkg::AGG_AVG, kra_pkg::AGG_COUNTS,
                  kra_pkg::AGG_ITEMS, kra_pkg::AGG_SUM, kra_pkg::AGG_AVG,
                  kra_pkg::AGG_COUNTS};
    groupings = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    for (int p = 0; p < 10; p++) begin
      if (p >= 8) begin
        set_config(kra_pkg::agg_mode_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else begin
        set_config(modes[p], groupings[p]);
      end
      run_batches(ItemsPerPhase);
    end
    send_record(pick_word(100), pick_word(100), pick_word(3), 1'b1);

    wait_idle();
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
